// File: sv/perceptron_threshold_trainer_macros.svh
// ----------------------------------------------------------------------------
// Perceptron threshold trainer assertion macros
// Shared concurrent assertion forms, clocked on clk with active-low reset.
// ----------------------------------------------------------------------------
`ifndef PERCEPTRON_THRESHOLD_TRAINER_MACROS_SVH
`define PERCEPTRON_THRESHOLD_TRAINER_MACROS_SVH

// Check that cond holds in the cycle after trig.
`define PTT_ASSERT_NEXT(label, clk, rst_n, trig, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error("assertion failed: next-cycle check");

// Check that cond holds in the same cycle as trig.
`define PTT_ASSERT_SAME(label, clk, rst_n, trig, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error("assertion failed: same-cycle check");

`endif

// File: sv/ptt_pkg.sv
// ----------------------------------------------------------------------------
// ptt_pkg
// Types, field widths and reset constants of the perceptron threshold trainer.
// ----------------------------------------------------------------------------
package ptt_pkg;

  // Fixed field widths
  localparam int PIX_W   = 15;
  localparam int THR_W   = 16;
  localparam int SUM_W   = 16;
  localparam int ADJ_W   = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET    = 2'd1;

  // Register reset values
  localparam logic [THR_W-1:0] THRESHOLD_RESET = 16'd35;
  localparam logic [PIX_W-1:0] TARGET_RESET    = 15'd18925;

  // Initial weights for pixels 0..14
  localparam int INIT_COUNT = 15;
  localparam int INIT_WEIGHTS [INIT_COUNT] = '{1, 2, 3, 4, 5, 6, 7, 8, 9, 10,
                                               12, 13, 14, 15, 0};

  // Adjustment codes reported with each result
  typedef enum logic [ADJ_W-1:0] {
    ADJ_NONE  = 2'd0,
    ADJ_RAISE = 2'd1,
    ADJ_LOWER = 2'd2
  } adj_t;

  // Weight update command broadcast to the lanes
  typedef struct packed {
    logic raise;
    logic lower;
  } upd_t;

endpackage

// File: sv/ptt_if.sv
// ----------------------------------------------------------------------------
// ptt_if
// Valid/ready channels for pattern words and result words.
// ----------------------------------------------------------------------------
interface ptt_in_if;
  import ptt_pkg::*;

  logic             valid;
  logic             ready;
  logic             req_type;
  logic [PIX_W-1:0] pixels;

  modport source (output valid, output req_type, output pixels, input ready);
  modport sink   (input valid, input req_type, input pixels, output ready);
endinterface

interface ptt_out_if;
  import ptt_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [SUM_W-1:0] weighted_sum;
  logic                    fires;
  logic [ADJ_W-1:0]        adjustment;

  modport source (output valid, output weighted_sum, output fires, output adjustment,
                  input ready);
  modport sink   (input valid, input weighted_sum, input fires, input adjustment,
                  output ready);
endinterface

// File: sv/perceptron_threshold_trainer.sv
// ----------------------------------------------------------------------------
// perceptron_threshold_trainer
// Single-layer perceptron that classifies pixel patterns and trains itself.
//
// Usage:
//   in_ch carries pattern words (req_type, pixels); out_ch carries one result
//   word per pattern (weighted_sum, fires, adjustment). Both are valid/ready.
//   cfg_we/cfg_index/cfg_data write the threshold (index 0) and the target
//   pattern (index 1); write them only while no word is in flight.
//   out_ch.valid rises in the cycle after acceptance. Throughput is one
//   pattern per cycle while the receiver keeps up: every lane reads, sums
//   and updates its weight in the same cycle, so the loop through the adder
//   tree, the threshold compare and the lane update sets the clock period.
//   A result register decouples the channels: a new pattern is taken while
//   the last result waits, as long as out_ch.ready is high in that cycle.
//   When the receiver stalls the result holds and in_ch.ready drops.
//   Reset (rst_n low, synchronous) loads the initial weight table, the
//   default threshold and target, and empties the result register.
// ----------------------------------------------------------------------------
`include "perceptron_threshold_trainer_macros.svh"

module perceptron_threshold_trainer #(
  parameter int NUM_PIXELS  = 15,
  parameter int WEIGHT_BITS = 12
) (
  input  logic                             clk,
  input  logic                             rst_n,
  ptt_in_if.sink                           in_ch,
  ptt_out_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [ptt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ptt_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import ptt_pkg::*;

  // Pixels at or above the field width never get set
  localparam int LANES = (NUM_PIXELS < PIX_W) ? NUM_PIXELS : PIX_W;
  localparam int SW    = (WEIGHT_BITS + 4 > THR_W + 1) ? WEIGHT_BITS + 4 : THR_W + 1;
  localparam logic [PIX_W-1:0] PIX_MASK = {PIX_W{1'b1}} >> (PIX_W - LANES);

  logic signed [THR_W-1:0] threshold_r;
  logic [PIX_W-1:0]        target_r;

  logic                    out_valid_r;
  logic signed [SUM_W-1:0] out_sum_r;
  logic                    out_fires_r;
  adj_t                    out_adj_r;

  logic                    accept;
  logic [PIX_W-1:0]        pix_m;
  logic                    match;
  logic signed [WEIGHT_BITS-1:0] contrib [LANES];
  logic signed [SW-1:0]    sum;
  logic                    fires;
  upd_t                    upd;
  adj_t                    adj;

  // Take a word whenever the result register is empty or drains this cycle
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign pix_m       = in_ch.pixels & PIX_MASK;
  assign match       = pix_m == (target_r & PIX_MASK);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= THRESHOLD_RESET;
      target_r    <= TARGET_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_THRESHOLD: threshold_r <= cfg_data;
        REG_TARGET:    target_r    <= cfg_data[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  // Weight lanes
  for (genvar j = 0; j < LANES; j++) begin : g_lane
    ptt_lane #(
      .W    (WEIGHT_BITS),
      .INIT (WEIGHT_BITS'(INIT_WEIGHTS[j]))
    ) u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .pix_bit (pix_m[j]),
      .upd     (accept ? upd : upd_t'('0)),
      .contrib (contrib[j])
    );
  end

  // Sum, threshold and training decision
  ptt_merge #(
    .LANES (LANES),
    .W     (WEIGHT_BITS),
    .SW    (SW)
  ) u_merge (
    .contrib   (contrib),
    .threshold (threshold_r),
    .match     (match),
    .train     (in_ch.req_type),
    .sum       (sum),
    .fires     (fires),
    .upd       (upd),
    .adj       (adj)
  );

  // Result register: load on accept, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_sum_r   <= sum[SUM_W-1:0];
      out_fires_r <= fires;
      out_adj_r   <= adj;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.weighted_sum = out_sum_r;
  assign out_ch.fires        = out_fires_r;
  assign out_ch.adjustment   = out_adj_r;

  // Checks
  `PTT_ASSERT_NEXT(a_accept_gives_result, clk, rst_n, accept, out_valid_r)
  `PTT_ASSERT_NEXT(a_classify_no_adjust, clk, rst_n, accept && !in_ch.req_type, out_adj_r == ADJ_NONE)
  `PTT_ASSERT_SAME(a_raise_not_fired, clk, rst_n, out_valid_r && (out_adj_r == ADJ_RAISE), !out_fires_r)
  `PTT_ASSERT_SAME(a_lower_fired, clk, rst_n, out_valid_r && (out_adj_r == ADJ_LOWER), out_fires_r)

endmodule

// File: sv/ptt_lane.sv
// ----------------------------------------------------------------------------
// ptt_lane
// One pixel lane: holds a saturating weight and gates it by its pixel bit.
// ----------------------------------------------------------------------------
module ptt_lane #(
  parameter int                W    = 12,
  parameter logic signed [W-1:0] INIT = '0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                pix_bit,
  input  ptt_pkg::upd_t       upd,
  output logic signed [W-1:0] contrib
);
  import ptt_pkg::*;

  localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

  logic signed [W-1:0] weight_r;
  logic signed [W-1:0] weight_nxt;

  // Gate the weight by the pixel
  assign contrib = pix_bit ? weight_r : '0;

  // Step the weight on a set pixel, hold at the limits
  always_comb begin
    weight_nxt = weight_r;
    if (pix_bit && upd.raise && (weight_r != WMAX)) begin
      weight_nxt = weight_r + W'(1);
    end else if (pix_bit && upd.lower && (weight_r != WMIN)) begin
      weight_nxt = weight_r - W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_r <= INIT;
    end else begin
      weight_r <= weight_nxt;
    end
  end

endmodule

// File: sv/ptt_merge.sv
// ----------------------------------------------------------------------------
// ptt_merge
// Adds the lane contributions in a tree, compares against the threshold and
// picks the training decision.
// ----------------------------------------------------------------------------
module ptt_merge #(
  parameter int LANES = 15,
  parameter int W     = 12,
  parameter int SW    = 17
) (
  input  logic signed [W-1:0]              contrib [LANES],
  input  logic signed [ptt_pkg::THR_W-1:0] threshold,
  input  logic                             match,
  input  logic                             train,
  output logic signed [SW-1:0]             sum,
  output logic                             fires,
  output ptt_pkg::upd_t                    upd,
  output ptt_pkg::adj_t                    adj
);
  import ptt_pkg::*;

  localparam int TN = 1 << $clog2(LANES);

  logic signed [SW-1:0] node [2*TN-1];

  // Load the leaves, pad the unused ones with zero
  for (genvar i = 0; i < TN; i++) begin : g_leaf
    if (i < LANES) begin : g_used
      assign node[TN-1+i] = SW'(contrib[i]);
    end else begin : g_pad
      assign node[TN-1+i] = '0;
    end
  end

  // Pairwise adder tree
  for (genvar n = 0; n < TN-1; n++) begin : g_node
    assign node[n] = node[2*n+1] + node[2*n+2];
  end

  assign sum   = node[0];
  assign fires = sum > SW'(threshold);

  // Perceptron rule
  always_comb begin
    upd = '0;
    adj = ADJ_NONE;
    if (train && match && !fires) begin
      upd.raise = 1'b1;
      adj       = ADJ_RAISE;
    end else if (train && !match && fires) begin
      upd.lower = 1'b1;
      adj       = ADJ_LOWER;
    end
  end

endmodule
